[rtl/core/atm_pkg.sv]
// Shared types, codes and pattern compare for the AT acknowledgement matcher.
`timescale 1ns / 1ps

package atm_pkg;

  localparam int BUFFER_BYTES = 1024;
  localparam int COUNT_W      = $clog2(BUFFER_BYTES);
  localparam int WINDOW_DEPTH = 8;
  localparam int PATTERNS     = 4;
  localparam int TIMEOUT_W    = 16;

  localparam logic [COUNT_W-1:0]   COUNT_LIMIT   = COUNT_W'(BUFFER_BYTES - 1);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;
  localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = 16'hFFFF;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [2:0] ACK_NONE  = 3'd0;
  localparam logic [2:0] ACK_OK    = 3'd1;
  localparam logic [2:0] ACK_ERROR = 3'd2;
  localparam logic [2:0] ACK_BUSY  = 3'd3;
  localparam logic [2:0] ACK_READY = 3'd4;

  localparam logic [1:0] CAUSE_MATCH   = 2'd0;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
  localparam logic [1:0] CAUSE_FULL    = 2'd2;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h00;

  typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] byte_value;
  } atm_item_t;

  typedef struct packed {
    logic [2:0] ack_code;
    logic [1:0] end_cause;
  } atm_result_t;

  typedef struct packed {
    logic        emit;
    logic        waiting;
    atm_result_t result;
  } atm_status_t;

  // Bit p is set when acknowledgement p ends at byte b; w[0] is the most recent byte.
  function automatic logic [PATTERNS-1:0] pattern_hits(input logic [7:0] b, input window_t w);
    logic [PATTERNS-1:0] h;
    h[0] = (b == CH_LF) && (w[0] == CH_CR) && (w[1] == "K") && (w[2] == "O");
    h[1] = (b == CH_LF) && (w[0] == CH_CR) && (w[1] == "R") && (w[2] == "O") &&
           (w[3] == "R") && (w[4] == "R") && (w[5] == "E");
    h[2] = (b == ".") && (w[0] == ".") && (w[1] == ".") && (w[2] == "p") &&
           (w[3] == " ") && (w[4] == "y") && (w[5] == "s") && (w[6] == "u") &&
           (w[7] == "b");
    h[3] = (b == CH_LF) && (w[0] == CH_CR) && (w[1] == "y") && (w[2] == "d") &&
           (w[3] == "a") && (w[4] == "e") && (w[5] == "r");
    return h;
  endfunction

endpackage

[rtl/core/at_response_ack_matcher.sv]
// Top level of the AT acknowledgement matcher for a UART reply stream.
//
// The in_ channel carries one beat per event: a start, a received UART byte or
// a one millisecond tick, selected by in_tuser. A start arms the matcher and
// clears its counters. Bytes build up lines; at each newline the line is
// checked for OK, ERROR, busy and ready acknowledgements in that priority.
// The wait also ends with no acknowledgement when the ticks reach timeout_ms
// or when the byte buffer fills. Each ended wait yields one beat on the out_
// channel; other input beats yield none.
// The timeout register is written through cfg_wr_en and cfg_wr_data and resets
// to 2000. The user must write it only while the block is idle; the block
// itself does not enforce this. A beat is registered at the input, decided by
// one level of logic and the result registered at the output. One input beat
// is taken every cycle unless the receiver stalls a held result.
// Reset clears the wait and leaves both channels empty. When the receiver
// stalls, the finished result is held; one further input beat is taken into
// the input register and in_tready then drops until the result is taken.
`timescale 1ns / 1ps

module at_response_ack_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] byte_value
  input  logic [1:0]  in_tuser,    // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [2:0] ack_code, [7:3] zero
  output logic [1:0]  out_tuser,   // [1:0] end_cause
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [atm_pkg::TIMEOUT_W-1:0] timeout_r;
  logic                          item_valid;
  atm_pkg::atm_item_t            in_item;
  atm_pkg::atm_item_t            item;
  atm_pkg::atm_status_t          status;
  atm_pkg::atm_result_t          out_result;
  logic                          out_free;
  logic                          take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= atm_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  assign in_item = '{func: in_tuser, byte_value: in_tdata};
  assign take    = item_valid && out_free;

  atm_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  atm_matcher u_matcher (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .item       (item),
    .timeout_ms (timeout_r),
    .status     (status)
  );

  atm_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .status     (status),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_free   (out_free),
    .out_result (out_result)
  );

  assign out_tdata = {5'b0, out_result.ack_code};
  assign out_tuser = out_result.end_cause;

  a_stall_only_on_output : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a held result");

  a_end_clears_wait : assert property (@(posedge clk) disable iff (!rst_n)
    (take && status.emit) |=> !status.waiting)
    else $error("wait still armed after a result");

  a_match_has_code : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == atm_pkg::CAUSE_MATCH)) |-> (out_tdata[2:0] != atm_pkg::ACK_NONE))
    else $error("matched result without an acknowledgement code");

  a_emit_only_when_waiting : assert property (@(posedge clk) disable iff (!rst_n)
    (take && status.emit) |-> status.waiting)
    else $error("result produced while idle");

endmodule

[rtl/core/atm_in_stage.sv]
// Input register slice holding one accepted beat for the matcher.
`timescale 1ns / 1ps

module atm_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  atm_pkg::atm_item_t in_item,
  input  logic              take,
  output logic              item_valid,
  output atm_pkg::atm_item_t item
);

  logic               valid_r;
  logic               valid_nxt;
  atm_pkg::atm_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

[rtl/core/atm_matcher.sv]
// Wait state, byte window, line flags and counters with the end decision.
`timescale 1ns / 1ps

module atm_matcher (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               take,
  input  atm_pkg::atm_item_t                 item,
  input  logic [atm_pkg::TIMEOUT_W-1:0]      timeout_ms,
  output atm_pkg::atm_status_t               status
);

  logic                              waiting_r, waiting_nxt;
  atm_pkg::window_t                  window_r, window_nxt;
  logic [atm_pkg::PATTERNS-1:0]      flags_r, flags_nxt;
  logic                              zero_r, zero_nxt;
  logic [atm_pkg::COUNT_W-1:0]       count_r, count_nxt;
  logic [atm_pkg::TIMEOUT_W-1:0]     elapsed_r, elapsed_nxt;

  logic [atm_pkg::COUNT_W-1:0]       count_inc;
  logic [atm_pkg::TIMEOUT_W-1:0]     elapsed_inc;
  logic                              zero_now;
  logic [atm_pkg::PATTERNS-1:0]      flags_all;
  logic                              emit;
  atm_pkg::atm_result_t              result;

  assign count_inc   = count_r + 1'b1;
  assign elapsed_inc = (elapsed_r == atm_pkg::ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign zero_now    = zero_r || (item.byte_value == atm_pkg::CH_ZERO);
  assign flags_all   = zero_now ? flags_r
                                : (flags_r | atm_pkg::pattern_hits(item.byte_value, window_r));

  always_comb begin
    waiting_nxt = waiting_r;
    window_nxt  = window_r;
    flags_nxt   = flags_r;
    zero_nxt    = zero_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    emit        = 1'b0;
    result      = '{ack_code: atm_pkg::ACK_NONE, end_cause: atm_pkg::CAUSE_MATCH};
    case (item.func)
      atm_pkg::FUNC_START: begin
        waiting_nxt = 1'b1;
        window_nxt  = '0;
        flags_nxt   = '0;
        zero_nxt    = 1'b0;
        count_nxt   = '0;
        elapsed_nxt = '0;
      end
      atm_pkg::FUNC_TICK: begin
        if (waiting_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= timeout_ms) begin
            waiting_nxt      = 1'b0;
            emit             = 1'b1;
            result.end_cause = atm_pkg::CAUSE_TIMEOUT;
          end
        end
      end
      atm_pkg::FUNC_BYTE: begin
        if (waiting_r) begin
          count_nxt  = count_inc;
          window_nxt = {window_r[atm_pkg::WINDOW_DEPTH-2:0], item.byte_value};
          flags_nxt  = flags_all;
          zero_nxt   = zero_now;
          if (item.byte_value == atm_pkg::CH_LF) begin
            flags_nxt = '0;
            zero_nxt  = 1'b0;
          end
          if ((item.byte_value == atm_pkg::CH_LF) && (flags_all != '0)) begin
            waiting_nxt = 1'b0;
            emit        = 1'b1;
            if (flags_all[0]) begin
              result.ack_code = atm_pkg::ACK_OK;
            end else if (flags_all[1]) begin
              result.ack_code = atm_pkg::ACK_ERROR;
            end else if (flags_all[2]) begin
              result.ack_code = atm_pkg::ACK_BUSY;
            end else begin
              result.ack_code = atm_pkg::ACK_READY;
            end
          end else if (count_inc >= atm_pkg::COUNT_LIMIT) begin
            waiting_nxt      = 1'b0;
            emit             = 1'b1;
            result.end_cause = atm_pkg::CAUSE_FULL;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign status = '{emit: emit, waiting: waiting_r, result: result};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      window_r  <= '0;
      flags_r   <= '0;
      zero_r    <= 1'b0;
      count_r   <= '0;
      elapsed_r <= '0;
    end else if (take) begin
      waiting_r <= waiting_nxt;
      window_r  <= window_nxt;
      flags_r   <= flags_nxt;
      zero_r    <= zero_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

[rtl/core/atm_out_stage.sv]
// Result register that holds a finished beat until the receiver takes it.
`timescale 1ns / 1ps

module atm_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  atm_pkg::atm_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_free,
  output atm_pkg::atm_result_t out_result
);

  logic                 valid_r, valid_nxt;
  atm_pkg::atm_result_t result_r;

  assign out_free   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = status.emit;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && status.emit) begin
      result_r <= status.result;
    end
  end

endmodule

[verif/at_response_ack_matcher_tb.sv]
// Self-checking testbench for the AT acknowledgement matcher.
`timescale 1ns / 1ps

module at_response_ack_matcher_tb;
  import atm_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int         WORD_BUSY   = 2;
  localparam int         PHASE_ITEMS = 220;

  class ack_scoreboard;
    string               ack_text[PATTERNS] = '{"OK\015\012", "ERROR\015\012", "busy p...",
                                                "ready\015\012"};
    logic [2:0]          ack_of[PATTERNS] = '{ACK_OK, ACK_ERROR, ACK_BUSY, ACK_READY};
    bit [15:0]           timeout_ms = TIMEOUT_RESET;
    bit                  armed;
    bit [7:0]            history[WINDOW_DEPTH];
    bit [PATTERNS-1:0]   line_hits;
    bit                  line_zeroed;
    int unsigned         bytes_seen;
    int unsigned         ticks_seen;
    atm_result_t         ack_queue[$];
    int                  mismatches;

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function void note_timeout(input bit [15:0] value);
      timeout_ms = value;
    endfunction

    function void arm();
      armed = 1'b1;
      foreach (history[i]) history[i] = 8'h00;
      line_hits   = '0;
      line_zeroed = 1'b0;
      bytes_seen  = 0;
      ticks_seen  = 0;
    endfunction

    // Does acknowledgement p finish with byte b, given the bytes already held?
    function bit ends_at(input int p, input bit [7:0] b);
      int n;
      n = ack_text[p].len();
      if (ack_text[p][n-1] != b) return 1'b0;
      for (int k = 1; k < n; k++) begin
        if (k - 1 >= WINDOW_DEPTH) return 1'b0;
        if (ack_text[p][n-1-k] != history[k-1]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Returns 1 when the beat is one that the matcher acts upon.
    function bit predict_ack(input bit [1:0] func, input bit [7:0] b);
      bit [PATTERNS-1:0] hits;
      if (func == FUNC_START) begin
        arm();
        return 1'b1;
      end
      if (!armed || func == FUNC_UNUSED) return 1'b0;
      if (func == FUNC_TICK) begin
        if (ticks_seen < ELAPSED_MAX) ticks_seen++;
        if (ticks_seen >= timeout_ms) begin
          armed = 1'b0;
          ack_queue.push_back(atm_result_t'{ACK_NONE, CAUSE_TIMEOUT});
        end
        return 1'b1;
      end
      bytes_seen++;
      if (b == CH_ZERO) line_zeroed = 1'b1;
      if (!line_zeroed) begin
        for (int p = 0; p < PATTERNS; p++) begin
          if (ends_at(p, b)) line_hits[p] = 1'b1;
        end
      end
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = b;
      if (b == CH_LF) begin
        hits        = line_hits;
        line_hits   = '0;
        line_zeroed = 1'b0;
        for (int p = 0; p < PATTERNS; p++) begin
          if (hits[p]) begin
            armed = 1'b0;
            ack_queue.push_back(atm_result_t'{ack_of[p], CAUSE_MATCH});
            return 1'b1;
          end
        end
      end
      if (bytes_seen >= BUFFER_BYTES - 1) begin
        armed = 1'b0;
        ack_queue.push_back(atm_result_t'{ACK_NONE, CAUSE_FULL});
      end
      return 1'b1;
    endfunction

    task check_ack(input logic [7:0] data, input logic [1:0] cause);
      atm_result_t want;
      if (ack_queue.size() == 0) begin
        report($sformatf("result beat with nothing pending: data %h cause %0d", data, cause));
        return;
      end
      want = ack_queue.pop_front();
      if (data !== {5'b00000, want.ack_code})
        report($sformatf("ack_code: got data %h, wanted code %0d", data, want.ack_code));
      if (cause !== want.end_cause)
        report($sformatf("end_cause: got %0d, wanted %0d", cause, want.end_cause));
    endtask
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;
  logic [1:0]  in_tuser    = FUNC_START;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  ack_scoreboard sb;
  int            send_idle_pct;
  int            recv_stall_pct;
  bit            send_calm;
  bit            recv_calm;
  int            items_taken;
  logic [7:0]    line_bytes[$];

  at_response_ack_matcher DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
    out_tready <= (recv_stall_pct == 0 || recv_calm) ? 1'b1
                                                     : ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_ack(out_tdata, out_tuser);
  end

  task automatic send_item(input logic [1:0] func, input logic [7:0] value);
    @(negedge clk);
    if (!send_calm) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= value;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (sb.predict_ack(func, value)) items_taken++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(FUNC_BYTE, s[i]);
  endtask

  task automatic drain();
    int guard = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.ack_queue.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.ack_queue.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.ack_queue.size()));
      sb.ack_queue.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.note_timeout(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic void add_word(input int w, input bit close_line);
    for (int i = 0; i < sb.ack_text[w].len(); i++) line_bytes.push_back(sb.ack_text[w][i]);
    if (w == WORD_BUSY && close_line) begin
      line_bytes.push_back(CH_CR);
      line_bytes.push_back(CH_LF);
    end
  endfunction

  function automatic void add_printable(input int count);
    repeat (count) line_bytes.push_back(8'($urandom_range(32, 126)));
  endfunction

  function automatic void build_line();
    int w = $urandom_range(0, PATTERNS - 1);
    int pos;
    line_bytes.delete();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        add_word(w, 1'b1);
      end
      4: begin
        add_printable($urandom_range(0, 12));
        if ($urandom_range(0, 1)) line_bytes.push_back(CH_CR);
        line_bytes.push_back(CH_LF);
      end
      5: begin
        add_printable($urandom_range(1, 10));
        add_word(w, 1'b1);
      end
      6: begin
        if ($urandom_range(0, 1)) begin
          line_bytes.push_back(CH_ZERO);
          add_word(w, 1'b1);
        end else begin
          add_word(WORD_BUSY, 1'b0);
          line_bytes.push_back(CH_ZERO);
          add_printable($urandom_range(0, 4));
          line_bytes.push_back(CH_CR);
          line_bytes.push_back(CH_LF);
        end
      end
      7: begin
        add_word(w, 1'b1);
        pos = $urandom_range(0, line_bytes.size() - 1);
        line_bytes[pos] = 8'($urandom);
      end
      8: begin
        add_word(WORD_BUSY, 1'b0);
        add_word(w, 1'b1);
      end
      default: begin
        repeat ($urandom_range(1, 16)) line_bytes.push_back(8'($urandom));
        line_bytes.push_back(CH_LF);
      end
    endcase
  endfunction

  task automatic run_episode(input int tick_pct);
    send_calm = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(5, 30)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
      return;
    end
    send_item(FUNC_START, 8'($urandom));
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 15) == 0) send_item(FUNC_START, 8'($urandom));
      build_line();
      foreach (line_bytes[i]) begin
        if ($urandom_range(0, 99) < tick_pct) send_item(FUNC_TICK, 8'($urandom));
        if ($urandom_range(0, 49) == 0) send_item(FUNC_UNUSED, 8'($urandom));
        send_item(FUNC_BYTE, line_bytes[i]);
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 30)) send_item(FUNC_TICK, 8'($urandom));
    end
  endtask

  // Fills the byte buffer; with a closing OK the last byte completes the acknowledgement.
  task automatic fill_buffer(input bit end_with_ok);
    logic [7:0] filler;
    send_item(FUNC_START, 8'h00);
    repeat (end_with_ok ? BUFFER_BYTES - 5 : BUFFER_BYTES - 1) begin
      filler = 8'($urandom_range(1, 255));
      send_item(FUNC_BYTE, (filler == CH_LF) ? 8'h2E : filler);
    end
    if (end_with_ok) send_text(sb.ack_text[0]);
  endtask

  task automatic run_phase(input logic [15:0] timeout, input int idle_pct, input int stall_pct,
                           input int tick_pct);
    write_timeout(timeout);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    items_taken    = 0;
    while (items_taken < PHASE_ITEMS) run_episode(tick_pct);
    send_calm = 1'b0;
    drain();
  endtask

  initial begin
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_TICK, 8'h00);
    send_item(FUNC_UNUSED, 8'h5A);
    send_item(FUNC_START, 8'h00);
    send_item(FUNC_BYTE, CH_LF);
    send_item(FUNC_START, 8'hA5);
    send_text(sb.ack_text[0]);
    send_item(FUNC_START, 8'hFF);
    send_text(sb.ack_text[WORD_BUSY]);
    send_item(FUNC_BYTE, CH_LF);
    drain();

    write_timeout(16'h0000);
    send_item(FUNC_START, 8'h00);
    send_item(FUNC_TICK, 8'hFF);
    drain();

    write_timeout(16'hFFFF);
    fill_buffer(1'b0);
    drain();

    run_phase(16'd24, 0, 0, 8);
    run_phase(16'd7, 76, 0, 5);
    run_phase(16'd1, 0, 76, 1);
    run_phase(16'd12, 33, 33, 6);

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/atm_pkg.sv
rtl/core/atm_in_stage.sv
rtl/core/atm_matcher.sv
rtl/core/atm_out_stage.sv
rtl/core/at_response_ack_matcher.sv
verif/at_response_ack_matcher_tb.sv
